// ----- src/kcl_pkg.sv -----
// Shared types and constants for the keypad code lock controller.
package kcl_pkg;

   localparam int unsigned BUTTON_W = 4;
   localparam int unsigned DIGIT_W = 3;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned DEBOUNCE_W = 10;
   localparam int unsigned STEP_W = 8;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CODE_REGS = 4;

   typedef enum logic [2:0] {
      PH_SCAN    = 3'd0,
      PH_PRESS   = 3'd1,
      PH_RELEASE = 3'd2,
      PH_SETTLE  = 3'd3,
      PH_OPEN    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CHECK_NONE     = 2'd0,
      CHECK_MATCH    = 2'd1,
      CHECK_MISMATCH = 2'd2
   } check_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODE_FIRST   = 4'd0,
      CSR_CODE_SECOND  = 4'd1,
      CSR_CODE_THIRD   = 4'd2,
      CSR_CODE_FOURTH  = 4'd3,
      CSR_DEBOUNCE     = 4'd4,
      CSR_TIMEOUT      = 4'd5,
      CSR_BLINK_PERIOD = 4'd6,
      CSR_OPEN_STEPS   = 4'd7
   } csr_index_type;

   // Classified tick sample passed from the front end to the engine
   typedef struct packed {
      logic [BUTTON_W-1:0] buttons;
      logic [DIGIT_W-1:0]  lowest;
   } item_type;

   typedef struct packed {
      logic               relay_open;
      logic               led_on;
      logic [DIGIT_W-1:0] key_accepted;
      logic [DIGIT_W-1:0] digits_entered;
      logic [1:0]         check_outcome;
   } result_type;

endpackage

// ----- src/keypad_code_lock_controller.sv -----
// Keypad code lock controller: one button sample per tick, one result per sample.
// A sample is registered in the front queue; its result is registered in the result queue.
// Throughput: one sample per cycle while the result queue has room; the engine steps one tick per transfer.
// A two-entry queue on each side of the engine lets input and result stall separately.
// Synchronous reset: queues empty, lock shut with LED on, registers at their defaults.
module keypad_code_lock_controller #(
   parameter int unsigned CODE_LENGTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic [3:0]                      req_buttons,
   output logic                            req_full,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_relay_open,
   output logic                            rsp_led_on,
   output logic [2:0]                      rsp_key_accepted,
   output logic [2:0]                      rsp_digits_entered,
   output logic [1:0]                      rsp_check_outcome,
   input  logic                            csr_write_en,
   input  logic [kcl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kcl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   kcl_pkg::item_type   item;
   logic                item_empty;
   logic                item_pop;
   kcl_pkg::result_type eng_data;
   logic                eng_push;
   logic                eng_full;
   kcl_pkg::result_type rsp_data;

   kcl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_buttons (req_buttons),
      .req_full    (req_full),
      .item_pop    (item_pop),
      .item_empty  (item_empty),
      .item        (item)
   );

   kcl_engine #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item_empty   (item_empty),
      .item         (item),
      .item_pop     (item_pop),
      .rsp_full     (eng_full),
      .rsp_push     (eng_push),
      .rsp_data     (eng_data)
   );

   kcl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .push_data (eng_data),
      .full      (eng_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_data)
   );

   assign rsp_relay_open     = rsp_data.relay_open;
   assign rsp_led_on         = rsp_data.led_on;
   assign rsp_key_accepted   = rsp_data.key_accepted;
   assign rsp_digits_entered = rsp_data.digits_entered;
   assign rsp_check_outcome  = rsp_data.check_outcome;

endmodule

// ----- src/kcl_front.sv -----
// Front end: accepts tick samples, picks the lowest pressed button, queues them.
module kcl_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic [kcl_pkg::BUTTON_W-1:0]      req_buttons,
   output logic                              req_full,
   input  logic                              item_pop,
   output logic                              item_empty,
   output kcl_pkg::item_type                 item
);

   kcl_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              do_push;
   logic              do_pop;
   kcl_pkg::item_type classified;

   always_comb begin
      classified.buttons = req_buttons;
      priority if (req_buttons[0]) begin
         classified.lowest = 3'd1;
      end else if (req_buttons[1]) begin
         classified.lowest = 3'd2;
      end else if (req_buttons[2]) begin
         classified.lowest = 3'd3;
      end else if (req_buttons[3]) begin
         classified.lowest = 3'd4;
      end else begin
         classified.lowest = 3'd0;
      end
   end

   assign req_full   = (count_ff == 2'd2);
   assign item_empty = (count_ff == 2'd0);
   assign item       = entry_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = item_pop && !item_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ----- src/kcl_engine.sv -----
// Lock engine: debounce, code entry, compare and door timing, one tick per transfer.
module kcl_engine #(
   parameter int unsigned CODE_LENGTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [kcl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kcl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               item_empty,
   input  kcl_pkg::item_type                  item,
   output logic                               item_pop,
   input  logic                               rsp_full,
   output logic                               rsp_push,
   output kcl_pkg::result_type                rsp_data
);

   localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam logic [kcl_pkg::DIGIT_W-1:0] LAST_DIGIT = kcl_pkg::DIGIT_W'(CODE_LENGTH - 1);

   // configuration
   logic [kcl_pkg::DIGIT_W-1:0]    code_ff [kcl_pkg::CODE_REGS];
   logic [kcl_pkg::DEBOUNCE_W-1:0] debounce_ff;
   logic [kcl_pkg::COUNT_W-1:0]    timeout_ff;
   logic [kcl_pkg::COUNT_W-1:0]    blink_period_ff;
   logic [kcl_pkg::STEP_W-1:0]     open_steps_ff;

   // lock state
   kcl_pkg::phase_type             phase_ff;
   kcl_pkg::phase_type             phase_in;
   logic [kcl_pkg::DIGIT_W-1:0]    cand_ff;
   logic [kcl_pkg::DIGIT_W-1:0]    cand_in;
   logic [kcl_pkg::COUNT_W-1:0]    pc_ff;
   logic [kcl_pkg::COUNT_W-1:0]    pc_in;
   logic [kcl_pkg::COUNT_W-1:0]    idle_ff;
   logic [kcl_pkg::COUNT_W-1:0]    idle_in;
   logic [kcl_pkg::DIGIT_W-1:0]    digit_ff;
   logic [kcl_pkg::DIGIT_W-1:0]    digit_in;
   logic [kcl_pkg::STEP_W-1:0]     step_ff;
   logic [kcl_pkg::STEP_W-1:0]     step_in;
   logic                           relay_ff;
   logic                           relay_in;
   logic                           led_ff;
   logic                           led_in;
   logic [kcl_pkg::DIGIT_W-1:0]    entered_ff [CODE_LENGTH];

   logic                           fire;
   logic [kcl_pkg::COUNT_W:0]      pc_inc;
   logic [kcl_pkg::DEBOUNCE_W-1:0] dbn;
   logic [kcl_pkg::COUNT_W-1:0]    blink_min;
   logic [kcl_pkg::STEP_W-1:0]     steps_min;
   logic [kcl_pkg::STEP_W-1:0]     step_inc;
   logic [kcl_pkg::COUNT_W-1:0]    idle_sat;
   logic [kcl_pkg::DIGIT_W-1:0]    cand_m1;
   logic [kcl_pkg::DIGIT_W-1:0]    digit_base;
   logic                           held;
   logic                           count_done;
   logic                           blink_done;
   logic                           open_end;
   logic                           timeout_hit;
   logic                           key_done;
   logic                           round_done;
   logic                           code_match;
   logic [kcl_pkg::DIGIT_W-1:0]    key;
   kcl_pkg::check_type             outcome;

   assign fire     = !item_empty && !rsp_full;
   assign item_pop = fire;
   assign rsp_push = fire;

   assign pc_inc     = {1'b0, pc_ff} + 17'd1;
   assign dbn        = (debounce_ff == '0) ? 10'd1 : debounce_ff;
   assign blink_min  = (blink_period_ff == '0) ? 16'd1 : blink_period_ff;
   assign steps_min  = (open_steps_ff == '0) ? 8'd1 : open_steps_ff;
   assign step_inc   = step_ff + 8'd1;
   assign idle_sat   = (idle_ff == '1) ? idle_ff : idle_ff + 16'd1;
   assign cand_m1    = cand_ff - 3'd1;
   assign held       = item.buttons[cand_m1[1:0]];
   assign count_done = (pc_inc >= {7'd0, dbn});
   assign blink_done = (pc_inc >= {1'b0, blink_min});
   assign open_end   = (step_inc >= steps_min);
   assign timeout_hit = (phase_ff != kcl_pkg::PH_OPEN) && (digit_ff != '0)
                        && (idle_sat > timeout_ff);
   assign digit_base = timeout_hit ? '0 : digit_ff;
   assign key_done   = (phase_ff == kcl_pkg::PH_SETTLE) && count_done;
   assign round_done = key_done && (digit_base == LAST_DIGIT);

   // the final digit is the one being accepted this tick
   always_comb begin
      code_match = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (i == CODE_LENGTH - 1) begin
            if (cand_ff != code_ff[i]) begin
               code_match = 1'b0;
            end
         end else if (entered_ff[i] != code_ff[i]) begin
            code_match = 1'b0;
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         kcl_pkg::PH_SCAN: begin
            if (item.lowest != '0) begin
               phase_in = kcl_pkg::PH_PRESS;
            end
         end
         kcl_pkg::PH_PRESS: begin
            if (count_done) begin
               phase_in = held ? kcl_pkg::PH_RELEASE : kcl_pkg::PH_SCAN;
            end
         end
         kcl_pkg::PH_RELEASE: begin
            if (!held) begin
               phase_in = kcl_pkg::PH_SETTLE;
            end
         end
         kcl_pkg::PH_SETTLE: begin
            if (count_done) begin
               phase_in = (round_done && code_match) ? kcl_pkg::PH_OPEN : kcl_pkg::PH_SCAN;
            end
         end
         kcl_pkg::PH_OPEN: begin
            if (blink_done && open_end) begin
               phase_in = kcl_pkg::PH_SCAN;
            end
         end
         default: begin
            phase_in = kcl_pkg::PH_SCAN;
         end
      endcase
   end

   // datapath updates and tick outputs
   always_comb begin
      cand_in  = cand_ff;
      pc_in    = pc_ff;
      idle_in  = idle_sat;
      digit_in = digit_base;
      step_in  = step_ff;
      relay_in = relay_ff;
      led_in   = led_ff;
      key      = '0;
      outcome  = kcl_pkg::CHECK_NONE;
      unique case (phase_ff)
         kcl_pkg::PH_SCAN: begin
            if (item.lowest != '0) begin
               cand_in = item.lowest;
               pc_in   = '0;
            end
         end
         kcl_pkg::PH_PRESS: begin
            pc_in = count_done ? '0 : pc_inc[kcl_pkg::COUNT_W-1:0];
         end
         kcl_pkg::PH_RELEASE: begin
            if (!held) begin
               pc_in = '0;
            end
         end
         kcl_pkg::PH_SETTLE: begin
            pc_in = count_done ? '0 : pc_inc[kcl_pkg::COUNT_W-1:0];
            if (count_done) begin
               key     = cand_ff;
               idle_in = '0;
               if (round_done) begin
                  digit_in = '0;
                  if (code_match) begin
                     outcome  = kcl_pkg::CHECK_MATCH;
                     step_in  = '0;
                     relay_in = 1'b1;
                     led_in   = 1'b0;
                  end else begin
                     outcome = kcl_pkg::CHECK_MISMATCH;
                  end
               end else begin
                  digit_in = digit_base + 3'd1;
               end
            end
         end
         kcl_pkg::PH_OPEN: begin
            pc_in = blink_done ? '0 : pc_inc[kcl_pkg::COUNT_W-1:0];
            if (blink_done) begin
               if (open_end) begin
                  step_in  = '0;
                  relay_in = 1'b0;
                  led_in   = 1'b1;
               end else begin
                  step_in = step_inc;
                  led_in  = step_inc[0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data.relay_open     = relay_in;
      rsp_data.led_on         = led_in;
      rsp_data.key_accepted   = key;
      rsp_data.digits_entered = digit_in;
      rsp_data.check_outcome  = outcome;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff[0]      <= 3'd1;
         code_ff[1]      <= 3'd2;
         code_ff[2]      <= 3'd3;
         code_ff[3]      <= 3'd4;
         debounce_ff     <= 10'd40;
         timeout_ff      <= 16'd5000;
         blink_period_ff <= 16'd300;
         open_steps_ff   <= 8'd33;
      end else if (csr_write_en) begin
         case (kcl_pkg::csr_index_type'(csr_index))
            kcl_pkg::CSR_CODE_FIRST:   code_ff[0]      <= csr_wdata[2:0];
            kcl_pkg::CSR_CODE_SECOND:  code_ff[1]      <= csr_wdata[2:0];
            kcl_pkg::CSR_CODE_THIRD:   code_ff[2]      <= csr_wdata[2:0];
            kcl_pkg::CSR_CODE_FOURTH:  code_ff[3]      <= csr_wdata[2:0];
            kcl_pkg::CSR_DEBOUNCE:     debounce_ff     <= csr_wdata[9:0];
            kcl_pkg::CSR_TIMEOUT:      timeout_ff      <= csr_wdata;
            kcl_pkg::CSR_BLINK_PERIOD: blink_period_ff <= csr_wdata;
            kcl_pkg::CSR_OPEN_STEPS:   open_steps_ff   <= csr_wdata[7:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kcl_pkg::PH_SCAN;
         cand_ff  <= '0;
         pc_ff    <= '0;
         idle_ff  <= '0;
         digit_ff <= '0;
         step_ff  <= '0;
         relay_ff <= 1'b0;
         led_ff   <= 1'b1;
      end else if (fire) begin
         phase_ff <= phase_in;
         cand_ff  <= cand_in;
         pc_ff    <= pc_in;
         idle_ff  <= idle_in;
         digit_ff <= digit_in;
         step_ff  <= step_in;
         relay_ff <= relay_in;
         led_ff   <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && key_done) begin
         entered_ff[digit_base[IDX_W-1:0]] <= cand_ff;
      end
   end

endmodule

// ----- src/kcl_rsp_queue.sv -----
// Two-entry result queue between the engine and the result port.
module kcl_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kcl_pkg::result_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output kcl_pkg::result_type pop_data
);

   kcl_pkg::result_type entry_ff [2];
   logic                wr_ptr_ff;
   logic                wr_ptr_in;
   logic                rd_ptr_ff;
   logic                rd_ptr_in;
   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
